// File: rtl/core/tvte_pkg.sv
`timescale 1ns / 1ps
// package for the tween engine: payload structs, codes, constants, sine table function
// used by timed_value_tween_engine and its testbench
package tvte_pkg;

	localparam int TABLE_DEPTH_DEF  = 16;
	localparam int SINE_ENTRIES_DEF = 256;
	localparam int TARGET_BITS_DEF  = 8;
	localparam int SQUARE_HALVES    = 16;
	localparam int Q16_ONE          = 65536;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_TICK   = 3'd1;
	localparam logic [2:0] MODE_KILL   = 3'd2;
	localparam logic [2:0] MODE_FINISH = 3'd3;
	localparam logic [2:0] MODE_RESET  = 3'd4;

	localparam logic [1:0] CURVE_LINEAR = 2'd0;
	localparam logic [1:0] CURVE_SINE   = 2'd1;
	localparam logic [1:0] CURVE_SQUARE = 2'd2;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  target_id;
		logic [31:0] start_value;
		logic [31:0] final_value;
		logic [19:0] duration_ms;
		logic [1:0]  curve;
		logic        repeat_req;
		logic [19:0] delay_ms;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  write_target;
		logic [31:0] write_value;
		logic        last;
	} out_word_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [15:0] target;
		logic [31:0] start;
		logic [31:0] fin;
		logic [31:0] begin_ms;
		logic [19:0] duration;
		logic [19:0] delay;
		logic [1:0]  curve;
		logic        rpt;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	// sine table entry, elaborated into a constant per index
	function automatic logic [16:0] sine_q16(input int unsigned idx, input int unsigned ents);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		longint      s;
		logic [63:0] r;
		a = (64'(idx) * 64'd1686629713) / 64'(ents);
		a2 = (a * a) >> 30;
		term = a;
		s = longint'(a);
		for (int k = 1; k <= 7; k++) begin
			term = (term * a2) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		if (s < 0) s = 0;
		r = (64'(s) + 64'd8192) >> 14;
		if (r > 64'(Q16_ONE)) r = 64'(Q16_ONE);
		return r[16:0];
	endfunction

endpackage

// File: rtl/core/tvte_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, one-read ram with registered read data
// no dependencies
module tvte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/tvte_divider.sv
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// standalone, no package use
module tvte_divider #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], n_q[NW-1]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (run_q) begin
			if (!trial[DW]) begin
				r_q <= {1'b0, trial[DW-1:0]};
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DW-1:0], n_q[NW-1]};
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = n_q;
	assign rem = r_q[DW-1:0];
endmodule

// File: rtl/core/timed_value_tween_engine.sv
`timescale 1ns / 1ps
// Tween engine top level. Command channel: a word is taken when start is high
// and busy is low. Results leave on res with res_valid high for one cycle each;
// the receiver cannot stall them, and every command ends with one result
// whose last bit is set (kind done, or kind full for an add to a full table).
// The table sits in one ram, one entry per word, with registered read data.
// Add: a write state, then the closing result. Kill/finish/reset: a read,
// wait and evaluate state per entry visited, plus a shift pass on each removal.
// Tick: per entry in its active span a read and one 64-bit serial division
// for the curve; a wrapped period adds a second division first.
// A removal adds the shift pass. The serial divider dominates the tick time.
// Reset clears the count and state machine at once; no clearing pass runs.
// busy stays high from acceptance until the cycle after the closing result.
module timed_value_tween_engine #(
	parameter int TABLE_DEPTH  = tvte_pkg::TABLE_DEPTH_DEF,
	parameter int SINE_ENTRIES = tvte_pkg::SINE_ENTRIES_DEF,
	parameter int TARGET_BITS  = tvte_pkg::TARGET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tvte_pkg::in_word_t cmd,
	output logic               res_valid,
	output tvte_pkg::out_word_t res
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(SINE_ENTRIES);
	localparam int TW = TARGET_BITS;
	localparam logic [7:0] TMASK = 8'((1 << TW) - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ADD, ST_RD, ST_WAIT, ST_EVAL, ST_PDIV, ST_PWAIT,
		ST_CDIV, ST_CWAIT, ST_MUL, ST_FIN, ST_SH_RD, ST_SH_WAIT, ST_SH_WR,
		ST_DONE
	} state_t;

	state_t             state_q;
	tvte_pkg::in_word_t cmd_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      sh_q;
	logic               after_rm_q;
	tvte_pkg::entry_t   ent_q;
	logic [31:0]        t_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	tvte_pkg::entry_t   ram_wdata, ram_rdata;

	logic               div_start, div_done;
	logic [63:0]        div_num, div_quo;
	logic [31:0]        div_den, div_rem;

	logic signed [32:0] diff_q;
	logic signed [65:0] prod_q;
	logic [16:0]        sine_val;
	logic [SW-1:0]      sidx;
	logic [16:0]        sine_lut [SINE_ENTRIES];

	tvte_ram #(.WIDTH(tvte_pkg::ENTRY_BITS), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	tvte_divider #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	generate
		for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
			assign sine_lut[g] = tvte_pkg::sine_q16(g, SINE_ENTRIES);
		end
	endgenerate

	// sine index clamp
	assign sidx = (div_quo >= 64'(SINE_ENTRIES)) ? SW'(SINE_ENTRIES - 1) : div_quo[SW-1:0];
	assign sine_val = sine_lut[sidx];

	// combinational views of the entry just read
	logic [31:0] elapsed, tt;
	logic        match;
	assign elapsed = cmd_q.now_ms - ram_rdata.begin_ms;
	assign tt      = elapsed - 32'(ram_rdata.delay);
	assign match   = ram_rdata.target == 16'(cmd_q.target_id & TMASK);

	always_comb begin
		ram_raddr = (state_q == ST_SH_RD) ? AW'(sh_q + 1'b1) : AW'(idx_q);
		ram_we = 1'b0;
		ram_waddr = AW'(idx_q);
		ram_wdata = ent_q;
		div_start = 1'b0;
		div_num = '0;
		div_den = 32'(ent_q.duration);
		if (state_q == ST_ADD) begin
			ram_we = 1'b1;
			ram_waddr = AW'(count_q);
			ram_wdata.target = 16'(cmd_q.target_id & TMASK);
			ram_wdata.start = cmd_q.start_value;
			ram_wdata.fin = cmd_q.final_value;
			ram_wdata.begin_ms = cmd_q.now_ms;
			ram_wdata.duration = (cmd_q.duration_ms == '0) ? 20'd1 : cmd_q.duration_ms;
			ram_wdata.delay = cmd_q.delay_ms;
			ram_wdata.curve = cmd_q.curve;
			ram_wdata.rpt = cmd_q.repeat_req;
		end else if (state_q == ST_SH_WR) begin
			ram_we = 1'b1;
			ram_waddr = AW'(sh_q);
		end else if (state_q == ST_FIN && !after_rm_q) begin
			ram_we = 1'b1; // begin may have moved
		end
		if (state_q == ST_PDIV) begin
			div_start = 1'b1;
			div_num = 64'(t_q);
		end else if (state_q == ST_CDIV) begin
			div_start = 1'b1;
			case (ent_q.curve)
				tvte_pkg::CURVE_SINE:   div_num = 64'(t_q) * 64'(SINE_ENTRIES);
				tvte_pkg::CURVE_SQUARE: div_num = 64'(t_q) * 64'(tvte_pkg::SQUARE_HALVES);
				default:                div_num = 64'(prod_q);
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			sh_q       <= '0;
			after_rm_q <= 1'b0;
			ent_q      <= '0;
			t_q        <= '0;
			diff_q     <= '0;
			prod_q     <= '0;
			res_valid  <= 1'b0;
			res        <= '0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						idx_q <= '0;
						if (cmd.mode == tvte_pkg::MODE_ADD) begin
							if (count_q >= CW'(TABLE_DEPTH)) begin
								res_valid <= 1'b1;
								res <= '{kind: tvte_pkg::KIND_FULL, write_target: '0,
									write_value: '0, last: 1'b1};
								state_q <= ST_DONE;
							end else state_q <= ST_ADD;
						end else if (cmd.mode inside {tvte_pkg::MODE_TICK, tvte_pkg::MODE_KILL,
								tvte_pkg::MODE_FINISH, tvte_pkg::MODE_RESET}) begin
							state_q <= ST_RD;
						end else state_q <= ST_FIN;
						after_rm_q <= 1'b1;
					end
				end
				ST_ADD: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_FIN;
					after_rm_q <= 1'b1;
				end
				ST_RD: begin
					if (idx_q >= count_q) begin
						after_rm_q <= 1'b1;
						state_q <= ST_FIN;
					end else state_q <= ST_WAIT;
				end
				ST_WAIT: state_q <= ST_EVAL;
				ST_EVAL: begin
					ent_q <= ram_rdata;
					diff_q <= 33'(signed'(ram_rdata.fin)) - 33'(signed'(ram_rdata.start));
					t_q <= tt;
					if (cmd_q.mode == tvte_pkg::MODE_TICK) begin
						if (elapsed <= 32'(ram_rdata.delay)) begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_RD;
						end else if (tt >= 32'(ram_rdata.duration)) begin
							if (ram_rdata.rpt) state_q <= ST_PDIV;
							else begin
								res_valid <= 1'b1;
								res <= '{kind: tvte_pkg::KIND_WRITE,
									write_target: ram_rdata.target[7:0],
									write_value: ram_rdata.fin, last: 1'b0};
								sh_q <= idx_q;
								state_q <= ST_SH_RD;
							end
						end else state_q <= ST_MUL;
					end else if (match) begin
						if (cmd_q.mode != tvte_pkg::MODE_KILL) begin
							res_valid <= 1'b1;
							res <= '{kind: tvte_pkg::KIND_WRITE,
								write_target: cmd_q.target_id & TMASK,
								write_value: (cmd_q.mode == tvte_pkg::MODE_FINISH) ?
									ram_rdata.fin : ram_rdata.start, last: 1'b0};
						end
						sh_q <= idx_q;
						state_q <= ST_SH_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_PDIV: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (div_done) begin
						ent_q.begin_ms <= ent_q.begin_ms + (t_q - div_rem);
						t_q <= div_rem;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// linear numerator diff * t, sign folded in after division
					prod_q <= 66'(diff_q < 0 ? -diff_q : diff_q) * 66'(t_q);
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					state_q <= ST_CWAIT;
				end
				ST_CWAIT: begin
					if (div_done) begin
						res_valid <= 1'b1;
						res.kind <= tvte_pkg::KIND_WRITE;
						res.write_target <= ent_q.target[7:0];
						res.last <= 1'b0;
						case (ent_q.curve)
							tvte_pkg::CURVE_SINE: begin
								res.write_value <= 32'(66'(signed'(ent_q.start)) +
									((66'(diff_q) * 66'(sine_val)) >>> 16));
							end
							tvte_pkg::CURVE_SQUARE: begin
								res.write_value <= div_quo[0] ? ent_q.fin : ent_q.start;
							end
							default: begin
								if (diff_q < 0)
									res.write_value <= ent_q.start - div_quo[31:0] -
										32'(div_rem != '0);
								else
									res.write_value <= ent_q.start + div_quo[31:0];
							end
						endcase
						after_rm_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (after_rm_q) begin
						res_valid <= 1'b1;
						res <= '{kind: tvte_pkg::KIND_DONE, write_target: '0,
							write_value: '0, last: 1'b1};
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SH_RD: begin
					if (sh_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_RD;
					end else state_q <= ST_SH_WAIT;
				end
				ST_SH_WAIT: state_q <= ST_SH_WR;
				ST_SH_WR: begin
					sh_q <= sh_q + 1'b1;
					state_q <= ST_SH_RD;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_SH_WAIT) ent_q <= ram_rdata;
		end
	end

	// shift write uses the entry caught in ST_SH_WAIT; ent_q latched there
	// (ram_rdata valid in the cycle after the ST_SH_RD address)

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(TABLE_DEPTH))
		else $error("entry count over depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> !res_valid)
		else $error("result after closing word");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |=> count_q == $past(count_q) + 1'b1)
		else $error("add did not grow table");
endmodule

// File: verif/timed_value_tween_engine_tb.sv
`timescale 1ns / 1ps
// testbench for timed_value_tween_engine: directed and random commands, with results
// predicted by an in-bench model of the tween table; depends on tvte_pkg and the rtl
module timed_value_tween_engine_tb;

	localparam int DEPTH = tvte_pkg::TABLE_DEPTH_DEF;
	localparam int SINE_N = tvte_pkg::SINE_ENTRIES_DEF;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tvte_pkg::in_word_t cmd;
	logic res_valid;
	tvte_pkg::out_word_t res;

	timed_value_tween_engine u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .res_valid(res_valid), .res(res)
	);

	typedef struct {
		logic [7:0]  tgt;
		logic [31:0] sv;
		logic [31:0] fv;
		logic [31:0] t0;
		logic [19:0] dur;
		logic [19:0] dly;
		logic [1:0]  crv;
		logic        rpt;
	} tween_t;

	tween_t tweens[$];
	tvte_pkg::out_word_t expected_words[$];
	int mismatches;
	int sender_idle_pct;
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint fdiv(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0) q--;
		return q;
	endfunction

	// quarter sine sample in Q16, Taylor series on a Q30 angle
	function automatic longint sine_sample(int unsigned idx);
		logic [63:0] a, a2, term;
		longint acc;
		logic [63:0] r;
		a = (64'(idx) * 64'd1686629713) / 64'(SINE_N);
		a2 = (a * a) >> 30;
		term = a;
		acc = longint'(a);
		for (int k = 1; k <= 7; k++) begin
			term = (term * a2) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		r = (64'(acc) + 64'd8192) >> 14;
		if (r > 64'd65536) r = 64'd65536;
		return longint'(r);
	endfunction

	function automatic logic [31:0] tween_value(tween_t w, logic [31:0] t);
		longint st, d, dur, v;
		longint unsigned idx, h;
		st = longint'(signed'(w.sv));
		d = longint'(signed'(w.fv)) - st;
		dur = longint'(w.dur);
		if (w.crv == tvte_pkg::CURVE_SINE) begin
			idx = (longint'(t) * SINE_N) / dur;
			if (idx >= SINE_N) idx = SINE_N - 1;
			v = st + fdiv(d * sine_sample(int'(idx)), 65536);
		end else if (w.crv == tvte_pkg::CURVE_SQUARE) begin
			h = (longint'(t) * 16) / dur;
			v = h[0] ? st + d : st;
		end else begin
			v = st + fdiv(d * longint'(t), dur);
		end
		return v[31:0];
	endfunction

	function automatic void push_word(logic [1:0] k, logic [7:0] tg, logic [31:0] v, logic l);
		tvte_pkg::out_word_t o;
		o.kind = k;
		o.write_target = tg;
		o.write_value = v;
		o.last = l;
		expected_words.insert(expected_words.size(), o);
	endfunction

	// advance the tween table by one command and queue the words it should produce
	function automatic void predict_command(tvte_pkg::in_word_t c);
		tween_t w;
		logic [31:0] t;
		int i;
		case (c.mode)
			tvte_pkg::MODE_ADD: begin
				if (tweens.size() >= DEPTH) begin
					push_word(tvte_pkg::KIND_FULL, 8'd0, 32'd0, 1'b1);
					return;
				end
				w.tgt = c.target_id;
				w.sv = c.start_value;
				w.fv = c.final_value;
				w.t0 = c.now_ms;
				w.dur = (c.duration_ms == 0) ? 20'd1 : c.duration_ms;
				w.dly = c.delay_ms;
				w.crv = c.curve;
				w.rpt = c.repeat_req;
				tweens.insert(tweens.size(), w);
			end
			tvte_pkg::MODE_TICK: begin
				i = 0;
				while (i < tweens.size()) begin
					w = tweens[i];
					t = c.now_ms - w.t0;
					if (t <= 32'(w.dly)) begin
						i++;
						continue;
					end
					t = t - 32'(w.dly);
					if (t >= 32'(w.dur)) begin
						if (w.rpt) begin
							tweens[i].t0 = w.t0 + (t / 32'(w.dur)) * 32'(w.dur);
							t = t % 32'(w.dur);
						end else begin
							push_word(tvte_pkg::KIND_WRITE, w.tgt, w.fv, 1'b0);
							tweens.delete(i);
							continue;
						end
					end
					push_word(tvte_pkg::KIND_WRITE, w.tgt, tween_value(w, t), 1'b0);
					i++;
				end
			end
			tvte_pkg::MODE_KILL, tvte_pkg::MODE_FINISH, tvte_pkg::MODE_RESET: begin
				i = 0;
				while (i < tweens.size()) begin
					if (tweens[i].tgt == c.target_id) begin
						if (c.mode == tvte_pkg::MODE_FINISH)
							push_word(tvte_pkg::KIND_WRITE, c.target_id, tweens[i].fv, 1'b0);
						else if (c.mode == tvte_pkg::MODE_RESET)
							push_word(tvte_pkg::KIND_WRITE, c.target_id, tweens[i].sv, 1'b0);
						tweens.delete(i);
					end else begin
						i++;
					end
				end
			end
			default: ;
		endcase
		push_word(tvte_pkg::KIND_DONE, 8'd0, 32'd0, 1'b1);
	endfunction

	// result checker
	always @(posedge clk) begin
		tvte_pkg::out_word_t e;
		if (arst_n && res_valid) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", res);
			end else begin
				e = expected_words.pop_front();
				if (res.kind !== e.kind || res.write_target !== e.write_target ||
					res.write_value !== e.write_value || res.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", e, res);
				end
			end
		end
	end

	task automatic send_command(tvte_pkg::in_word_t c);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
			@(posedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(c);
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic tvte_pkg::in_word_t make_add(logic [7:0] tg, logic [31:0] sv,
		logic [31:0] fv, logic [19:0] dur, logic [1:0] crv, logic rpt, logic [19:0] dly);
		tvte_pkg::in_word_t c;
		c.mode = tvte_pkg::MODE_ADD;
		c.target_id = tg;
		c.start_value = sv;
		c.final_value = fv;
		c.duration_ms = dur;
		c.curve = crv;
		c.repeat_req = rpt;
		c.delay_ms = dly;
		c.now_ms = clock_ms;
		return c;
	endfunction

	function automatic tvte_pkg::in_word_t make_op(logic [2:0] m, logic [7:0] tg);
		tvte_pkg::in_word_t c;
		c = tvte_pkg::in_word_t'($bits(tvte_pkg::in_word_t)'({$urandom, $urandom, $urandom,
			$urandom, $urandom}));
		c.mode = m;
		c.target_id = tg;
		c.now_ms = clock_ms;
		return c;
	endfunction

	task automatic tick_after(int unsigned dt);
		clock_ms = clock_ms + dt;
		send_command(make_op(tvte_pkg::MODE_TICK, 8'd0));
	endtask

	task automatic test_directed();
		send_command(make_add(8'hff, 32'h7fffffff, 32'h80000000, 20'd100,
			tvte_pkg::CURVE_LINEAR, 1'b0, 20'd0));
		send_command(make_add(8'h00, 32'h80000000, 32'h7fffffff, 20'd0,
			tvte_pkg::CURVE_SINE, 1'b1, 20'd5));
		send_command(make_add(8'h11, 32'h00010000, 32'hfff00000, 20'hfffff,
			tvte_pkg::CURVE_SQUARE, 1'b1, 20'hfffff));
		send_command(make_add(8'h22, 32'h0, 32'h00640000, 20'd64, 2'd3, 1'b0, 20'd2));
		send_command(make_add(8'h33, 32'h0, 32'h00640000, 20'd200,
			tvte_pkg::CURVE_SINE, 1'b0, 20'd0));
		tick_after(0);
		tick_after(1);
		tick_after(37);
		tick_after(90);
		send_command(make_op(tvte_pkg::MODE_FINISH, 8'h11));
		send_command(make_op(tvte_pkg::MODE_RESET, 8'h33));
		send_command(make_op(tvte_pkg::MODE_KILL, 8'h00));
		send_command(make_op(tvte_pkg::MODE_KILL, 8'h5a));
		send_command(make_op(3'd5, 8'h00));
		send_command(make_op(3'd7, 8'h00));
		// fill past capacity to hit the full report
		for (int k = 0; k < 18; k++)
			send_command(make_add(8'(k % 3), $urandom, $urandom, 20'd50, 2'(k % 4), k[0], 20'd0));
		clock_ms = 32'hffffffd0;
		tick_after(80);
		send_command(make_op(tvte_pkg::MODE_RESET, 8'd1));
		send_command(make_op(tvte_pkg::MODE_FINISH, 8'd2));
		send_command(make_op(tvte_pkg::MODE_KILL, 8'd0));
	endtask

	task automatic test_random(int n);
		int r;
		logic [19:0] dur;
		tvte_pkg::in_word_t c;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 35) begin
				dur = ($urandom_range(19) == 0) ? 20'($urandom) : 20'($urandom_range(400));
				c = make_add(8'($urandom_range(7)), $urandom, $urandom, dur,
					2'($urandom_range(3)), 1'($urandom), 20'($urandom_range(30)));
				if ($urandom_range(9) == 0) begin
					c.target_id = 8'($urandom);
					c.delay_ms = 20'($urandom);
				end
				send_command(c);
			end else if (r < 75) begin
				tick_after($urandom_range(120));
			end else if (r < 92) begin
				send_command(make_op(3'($urandom_range(2, 4)), 8'($urandom_range(7))));
			end else if (r < 96) begin
				c = make_op(3'($urandom_range(5, 7)), 8'($urandom));
				c.now_ms = $urandom;
				send_command(c);
			end else begin
				clock_ms = $urandom;
				tick_after(0);
			end
		end
	endtask

	task automatic drain_results();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		clock_ms = 32'd1000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_results();
		test_random(90);
		sender_idle_pct = 64;
		test_random(80);
		drain_results();
		sender_idle_pct = 21;
		test_random(60);
		sender_idle_pct = 0;
		test_random(40);
		drain_results();
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
